[rtl/bavf_pkg.sv]
// Shared types and constants for the barometric altitude and vario filter.
package bavf_pkg;

   localparam int TIME_W     = 32;
   localparam int ALPHA_W    = 16;
   localparam int INIT_W     = 12;
   localparam int GAIN_W     = 8;
   localparam int PERIOD_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int ASL_W      = 21;
   localparam int AGL_W      = 22;
   localparam int VARIO_W    = 16;
   localparam int RSP_W      = 64;
   localparam int RSP_PAD    = RSP_W - ASL_W - AGL_W - VARIO_W;
   localparam int CTR_W      = 7;

   localparam logic [CSR_IDX_W-1:0] REG_ALPHA  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD = 2'd3;

   localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd8897;
   localparam logic [INIT_W-1:0]   INIT_RESET   = 12'd1000;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 8'd20;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

   typedef enum logic [15:0] {
      ST_IDLE  = 16'b0000_0000_0000_0001,
      ST_CHECK = 16'b0000_0000_0000_0010,
      ST_ACC   = 16'b0000_0000_0000_0100,
      ST_MAG   = 16'b0000_0000_0000_1000,
      ST_DIV   = 16'b0000_0000_0001_0000,
      ST_NEG   = 16'b0000_0000_0010_0000,
      ST_DIFA  = 16'b0000_0000_0100_0000,
      ST_SMA   = 16'b0000_0000_1000_0000,
      ST_UPDA  = 16'b0000_0001_0000_0000,
      ST_AGL   = 16'b0000_0010_0000_0000,
      ST_DIFF  = 16'b0000_0100_0000_0000,
      ST_MUL   = 16'b0000_1000_0000_0000,
      ST_DIFV  = 16'b0001_0000_0000_0000,
      ST_SMV   = 16'b0010_0000_0000_0000,
      ST_UPDV  = 16'b0100_0000_0000_0000,
      ST_OUT   = 16'b1000_0000_0000_0000
   } state_type;

   typedef struct packed {
      state_type        st;
      logic [CTR_W-1:0] ctr;
      logic             take;
   } ctrl_type;

   typedef struct packed {
      logic due;
      logic ground;
   } status_type;

   typedef struct packed {
      logic [ALPHA_W-1:0]  alpha_q16;
      logic [INIT_W-1:0]   init_samples;
      logic [GAIN_W-1:0]   vario_gain;
      logic [PERIOD_W-1:0] sample_period_ms;
   } cfg_type;

endpackage

[rtl/bavf_seq.sv]
// Sequencer that steps the shared adder through the per-item schedule.
module bavf_seq #(
   parameter int SAMPLE_WIDTH = 21,
   parameter int FRAC_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                rsp_free,
   input  bavf_pkg::status_type status,
   output bavf_pkg::ctrl_type  ctrl,
   output logic                ready
);
   import bavf_pkg::*;

   localparam int DIV_STEPS = SAMPLE_WIDTH + INIT_W + FRAC_BITS;
   localparam logic [CTR_W-1:0] DIV_LAST    = CTR_W'(DIV_STEPS - 1);
   localparam logic [CTR_W-1:0] SMOOTH_LAST = CTR_W'(ALPHA_W - 1);
   localparam logic [CTR_W-1:0] MUL_LAST    = CTR_W'(GAIN_W - 1);

   state_type        st_ff, st_in;
   logic [CTR_W-1:0] ctr_ff, ctr_in;

   always_comb begin
      st_in  = st_ff;
      ctr_in = ctr_ff + CTR_W'(1);
      unique case (st_ff)
         ST_IDLE: begin
            if (req_valid) st_in = ST_CHECK;
         end
         ST_CHECK: begin
            ctr_in = '0;
            if (!status.due) st_in = ST_IDLE;
            else if (status.ground) st_in = ST_ACC;
            else st_in = ST_DIFA;
         end
         ST_ACC:  st_in = ST_MAG;
         ST_MAG: begin
            st_in  = ST_DIV;
            ctr_in = '0;
         end
         ST_DIV: begin
            if (ctr_ff == DIV_LAST) st_in = ST_NEG;
         end
         ST_NEG:  st_in = ST_AGL;
         ST_DIFA: begin
            st_in  = ST_SMA;
            ctr_in = '0;
         end
         ST_SMA: begin
            if (ctr_ff == SMOOTH_LAST) st_in = ST_UPDA;
         end
         ST_UPDA: st_in = ST_AGL;
         ST_AGL:  st_in = ST_DIFF;
         ST_DIFF: begin
            st_in  = ST_MUL;
            ctr_in = '0;
         end
         ST_MUL: begin
            if (ctr_ff == MUL_LAST) st_in = ST_DIFV;
         end
         ST_DIFV: begin
            st_in  = ST_SMV;
            ctr_in = '0;
         end
         ST_SMV: begin
            if (ctr_ff == SMOOTH_LAST) st_in = ST_UPDV;
         end
         ST_UPDV: st_in = ST_OUT;
         ST_OUT: begin
            // hold until the output register can take the item
            if (rsp_free) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         ctr_ff <= '0;
      end else begin
         st_ff  <= st_in;
         ctr_ff <= ctr_in;
      end
   end

   assign ready     = (st_ff == ST_IDLE);
   assign ctrl.st   = st_ff;
   assign ctrl.ctr  = ctr_ff;
   assign ctrl.take = (st_ff == ST_IDLE) && req_valid;

endmodule

[rtl/bavf_dp.sv]
// Datapath: filter state, working registers and the single shared adder.
module bavf_dp #(
   parameter int SAMPLE_WIDTH = 21,
   parameter int FRAC_BITS    = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bavf_pkg::ctrl_type                ctrl,
   input  bavf_pkg::cfg_type                 cfg,
   input  logic [bavf_pkg::TIME_W-1:0]       in_time,
   input  logic signed [SAMPLE_WIDTH-1:0]    in_alt,
   output bavf_pkg::status_type              status,
   output logic [bavf_pkg::ASL_W-1:0]        alt_asl,
   output logic [bavf_pkg::AGL_W-1:0]        alt_agl,
   output logic [bavf_pkg::VARIO_W-1:0]      vario,
   output logic                              ground_ready
);
   import bavf_pkg::*;

   localparam int SW    = SAMPLE_WIDTH;
   localparam int FB    = FRAC_BITS;
   localparam int AW    = SW + FB + 11;        // adder and accumulator
   localparam int VB    = SW + FB + 6;         // vario before smoothing
   localparam int GW    = SW + INIT_W;         // ground sum
   localparam int DW    = GW + FB;             // dividend / quotient
   localparam int QW    = SW + FB;             // filtered altitude
   localparam int AVW   = QW + 1;              // ground average
   localparam int PW    = QW + 2;              // altitude above ground
   localparam int SXW   = (SW > ASL_W) ? SW : ASL_W;
   localparam int AGW   = SW + 2;
   localparam int XW    = (AGW > AGL_W) ? AGW : AGL_W;
   localparam int VIW   = VB - FB;
   localparam int AIX_W = $clog2(ALPHA_W);
   localparam int GIX_W = $clog2(GAIN_W);

   logic [TIME_W-1:0]      time_ff, last_ff;
   logic signed [SW-1:0]   alt_ff;
   logic [INIT_W-1:0]      count_ff;
   logic signed [GW-1:0]   gsum_ff;
   logic signed [QW-1:0]   fasl_ff;
   logic signed [AVW-1:0]  avg_ff;
   logic signed [PW-1:0]   prev_ff;
   logic signed [VB-1:0]   fvar_ff;
   logic signed [AW-1:0]   acc_ff, opd_ff;
   logic [DW-1:0]          quo_ff;
   logic                   neg_ff;

   logic signed [QW-1:0]   alt_q;
   logic signed [AW-1:0]   op_a, op_b, sum, div_a;
   logic                   op_sub;
   logic                   ge;
   logic                   abit, gbit;
   logic                   vt_fits;
   logic signed [VB-1:0]   vtarget;

   assign alt_q = {alt_ff, {FB{1'b0}}};
   assign div_a = AW'({acc_ff[INIT_W-1:0], quo_ff[DW-1]});
   assign abit  = cfg.alpha_q16[ctrl.ctr[AIX_W-1:0]];
   assign gbit  = cfg.vario_gain[ctrl.ctr[GIX_W-1:0]];

   // clamp the scaled difference before it enters the vario filter
   assign vt_fits = (acc_ff[AW-1:VB-1] == {(AW-VB+1){acc_ff[AW-1]}});
   assign vtarget = vt_fits ? acc_ff[VB-1:0] :
                    (acc_ff[AW-1] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}});

   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_sub = 1'b0;
      unique case (ctrl.st)
         ST_CHECK: begin
            op_a   = AW'(time_ff);
            op_b   = AW'(last_ff);
            op_sub = 1'b1;
         end
         ST_ACC: begin
            op_a = AW'(gsum_ff);
            op_b = AW'(alt_ff);
         end
         ST_MAG: begin
            op_b   = AW'(gsum_ff);
            op_sub = gsum_ff[GW-1];
         end
         ST_DIV: begin
            op_a   = div_a;
            op_b   = AW'(count_ff);
            op_sub = 1'b1;
         end
         ST_NEG: begin
            op_b   = AW'(quo_ff[QW-1:0]);
            op_sub = neg_ff;
         end
         ST_DIFA: begin
            op_a   = AW'(alt_q);
            op_b   = AW'(fasl_ff);
            op_sub = 1'b1;
         end
         ST_SMA, ST_SMV: begin
            op_a = acc_ff;
            op_b = abit ? opd_ff : '0;
         end
         ST_UPDA: begin
            op_a = AW'(fasl_ff);
            op_b = acc_ff;
         end
         ST_AGL: begin
            op_a   = AW'(fasl_ff);
            op_b   = AW'(avg_ff);
            op_sub = 1'b1;
         end
         ST_DIFF: begin
            op_a   = acc_ff;
            op_b   = AW'(prev_ff);
            op_sub = 1'b1;
         end
         ST_MUL: begin
            op_a = acc_ff;
            op_b = gbit ? opd_ff : '0;
         end
         ST_DIFV: begin
            op_a   = AW'(vtarget);
            op_b   = AW'(fvar_ff);
            op_sub = 1'b1;
         end
         ST_UPDV: begin
            op_a = AW'(fvar_ff);
            op_b = acc_ff;
         end
         default: ;
      endcase
   end

   assign sum = op_a + (op_sub ? ~op_b : op_b) + AW'(op_sub);
   assign ge  = !sum[AW-1];

   assign status.due    = (sum[TIME_W-1:0] >= TIME_W'(cfg.sample_period_ms));
   assign status.ground = (count_ff < cfg.init_samples);

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         count_ff <= '0;
         gsum_ff  <= '0;
         fasl_ff  <= '0;
         avg_ff   <= '0;
         prev_ff  <= '0;
         fvar_ff  <= '0;
      end else begin
         unique case (ctrl.st)
            ST_CHECK: begin
               if (status.due) last_ff <= time_ff;
            end
            ST_ACC: begin
               gsum_ff  <= sum[GW-1:0];
               count_ff <= count_ff + INIT_W'(1);
               fasl_ff  <= alt_q;
            end
            ST_NEG:  avg_ff  <= sum[AVW-1:0];
            ST_UPDA: fasl_ff <= sum[QW-1:0];
            ST_DIFF: prev_ff <= acc_ff[PW-1:0];
            ST_UPDV: fvar_ff <= sum[VB-1:0];
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         time_ff <= in_time;
         alt_ff  <= in_alt;
      end
      unique case (ctrl.st)
         ST_MAG: begin
            quo_ff <= {sum[GW-1:0], {FB{1'b0}}};
            acc_ff <= '0;
            neg_ff <= gsum_ff[GW-1];
         end
         ST_DIV: begin
            // restoring step: keep the trial remainder when it did not go negative
            acc_ff <= ge ? sum : div_a;
            quo_ff <= {quo_ff[DW-2:0], ge};
         end
         ST_DIFA, ST_DIFF, ST_DIFV: begin
            opd_ff <= sum;
            acc_ff <= '0;
         end
         ST_SMA, ST_SMV: acc_ff <= sum >>> 1;
         ST_AGL:         acc_ff <= sum;
         ST_MUL: begin
            acc_ff <= sum;
            opd_ff <= opd_ff <<< 1;
         end
         default: ;
      endcase
   end

   // result fields
   logic signed [SXW-1:0] asl_x;
   logic signed [XW-1:0]  agl_x;
   logic signed [VIW-1:0] var_x;
   logic                  agl_fits, var_fits;

   assign asl_x   = SXW'($signed(fasl_ff[QW-1:FB]));
   assign alt_asl = asl_x[ASL_W-1:0];

   assign agl_x    = XW'($signed(prev_ff[PW-1:FB]));
   assign agl_fits = (agl_x[XW-1:AGL_W-1] == {(XW-AGL_W+1){agl_x[XW-1]}});
   assign alt_agl  = agl_fits ? agl_x[AGL_W-1:0] :
                     (agl_x[XW-1] ? {1'b1, {(AGL_W-1){1'b0}}} : {1'b0, {(AGL_W-1){1'b1}}});

   assign var_x    = fvar_ff[VB-1:FB];
   assign var_fits = (var_x[VIW-1:VARIO_W-1] == {(VIW-VARIO_W+1){var_x[VIW-1]}});
   assign vario    = var_fits ? var_x[VARIO_W-1:0] :
                     (var_x[VIW-1] ? {1'b1, {(VARIO_W-1){1'b0}}} :
                                     {1'b0, {(VARIO_W-1){1'b1}}});

   assign ground_ready = (count_ff >= cfg.init_samples);

endmodule

[rtl/baro_altitude_vario_filter.sv]
// A sample still in the ground phase and a filtered sample take different paths through the
// schedule, so their results come out at different times after they are taken.
// A sample that arrives before the period is up is dropped in the cycle after it is taken.
// One item at a time: the next item can be taken in the cycle after the result is registered.
// The serial divider (one quotient bit per cycle) and the 16-step smoothing multiplies are the longest steps.
// Synchronous reset clears the filter state, restores register defaults and empties the output.
module baro_altitude_vario_filter #(
   parameter int SAMPLE_WIDTH = 21,
   parameter int FRAC_BITS    = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // time_ms [31:0], altitude_cm [32+SAMPLE_WIDTH-1:32], zero pad
   input  logic [((32+SAMPLE_WIDTH+7)/8)*8-1:0]   req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // alt_asl_cm [20:0], alt_agl_cm [42:21], vario_cm [58:43], zero pad
   output logic [bavf_pkg::RSP_W-1:0]             rsp_tdata,
   // ground_ready [0]
   output logic                                   rsp_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bavf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bavf_pkg::CSR_DATA_W-1:0]        csr_data
);
   import bavf_pkg::*;

   cfg_type    cfg_ff;
   ctrl_type   ctrl;
   status_type status;

   logic                 rsp_valid_ff;
   logic [RSP_W-1:0]     rsp_data_ff;
   logic                 rsp_user_ff;
   logic                 rsp_free, rsp_load;
   logic [ASL_W-1:0]     alt_asl;
   logic [AGL_W-1:0]     alt_agl;
   logic [VARIO_W-1:0]   vario;
   logic                 ground_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_q16        <= ALPHA_RESET;
         cfg_ff.init_samples     <= INIT_RESET;
         cfg_ff.vario_gain       <= GAIN_RESET;
         cfg_ff.sample_period_ms <= PERIOD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ALPHA:  cfg_ff.alpha_q16        <= csr_data;
            REG_INIT:   cfg_ff.init_samples     <= csr_data[INIT_W-1:0];
            REG_GAIN:   cfg_ff.vario_gain       <= csr_data[GAIN_W-1:0];
            REG_PERIOD: cfg_ff.sample_period_ms <= csr_data[PERIOD_W-1:0];
         endcase
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = (ctrl.st == ST_OUT) && rsp_free;

   bavf_seq #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .rsp_free  (rsp_free),
      .status    (status),
      .ctrl      (ctrl),
      .ready     (req_tready)
   );

   bavf_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .cfg          (cfg_ff),
      .in_time      (req_tdata[TIME_W-1:0]),
      .in_alt       (req_tdata[TIME_W+SAMPLE_WIDTH-1:TIME_W]),
      .status       (status),
      .alt_asl      (alt_asl),
      .alt_agl      (alt_agl),
      .vario        (vario),
      .ground_ready (ground_ready)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {{RSP_PAD{1'b0}}, vario, alt_agl, alt_asl};
         rsp_user_ff <= ground_ready;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/bavf_checker.sv]
// Port-level checks for the altitude and vario filter, bound to the top level.
module bavf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // the block goes busy right after it takes an item
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   // a new result only comes out of a busy block
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while block was idle");

   // reset leaves the block idle with an empty output
   assert property (@(posedge clock)
      $past(reset) |-> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule

bind baro_altitude_vario_filter bavf_checker u_bavf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
